[sv/ffba_pkg.sv]
package ffba_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned SlotW       = $clog2(MaxBlocks);
  localparam int unsigned CountW      = SlotW + 1;
  localparam int unsigned SizeW       = 21;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned PageShift   = 12;
  localparam int unsigned EntryW      = SizeW + 1 + SlotW;

  localparam logic [31:0] BaseReset   = 32'hC000_0000;
  localparam logic [8:0]  FramesReset = 9'd16;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoSpace   = 3'd1,
    StNull      = 3'd2,
    StOutside   = 3'd3,
    StDouble    = 3'd4,
    StNotBlock  = 3'd5
  } status_e;

  localparam logic ActAlloc   = 1'b0;
  localparam logic ActRelease = 1'b1;

  localparam logic CfgBase   = 1'b0;
  localparam logic CfgFrames = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             free;
    logic [SlotW-1:0] next;
  } entry_t;

endpackage

[sv/first_fit_block_allocator_top.sv]
// First-fit heap allocator. Block table (size, free mark, next link) lives in one
// 64-entry synchronous RAM; slot 0 always heads the address-ordered list. An
// allocate walks the list one entry at a time (SARd, SAChk) until a fit, then
// writes back the split, with the new tail slot written afterwards in SLMove. A
// null release answers the cycle after it is accepted. Any other release walks
// to the matching block (SFRd, SFChk per entry), then one coalescing pass
// visits each adjacent pair (SCRd, SCChk, SCRdNx). Each merge costs a write-back
// plus, when a slot must be compacted, a predecessor scan; at most two merges
// happen per release. After reset or any configuration write the table is
// reinitialized. A result waits in an output register; until it is taken, new
// requests and configuration writes are held off.
module first_fit_block_allocator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffba_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffba_pkg::rsp_t    out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  localparam int unsigned SW = ffba_pkg::SlotW;
  localparam int unsigned CW = ffba_pkg::CountW;
  localparam int unsigned ZW = ffba_pkg::SizeW;

  typedef enum logic [3:0] {
    SIdle, SARd, SAChk, SFRd, SFChk, SCRd, SCChk, SCRdNx, SCMerge,
    SPRd, SPChk, SLRd, SLMove, SDone
  } state_e;

  state_e           state_q;
  logic [31:0]      base_q;
  logic [8:0]       frames_q;
  logic [CW-1:0]    count_q;
  ffba_pkg::req_t   req_q;
  logic [SW-1:0]    cur_q, nx_q, rem_q, p_q;
  logic [CW-1:0]    pos_q;
  logic [33:0]      off_q;
  ffba_pkg::entry_t cure_q, nxe_q;
  logic             init_q;
  logic             out_valid_q;
  ffba_pkg::rsp_t   out_q;

  logic             we;
  logic [SW-1:0]    waddr, raddr;
  ffba_pkg::entry_t wdata, rdata;
  logic [8:0]       frames_eff;
  logic [20:0]      heap_bytes;
  logic [33:0]      need;
  logic [31:0]      rel;
  logic [SW-1:0]    last;

  ffba_ram #(.Width(ffba_pkg::EntryW), .Depth(ffba_pkg::MaxBlocks)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // slot 0 is virtual after init until first written back
  ffba_pkg::entry_t rd_e;
  logic             rd0_q;
  always_comb begin
    rd_e = rdata;
    if (init_q && rd0_q) begin
      rd_e = '{size: ZW'(heap_bytes - 21'(ffba_pkg::HeaderBytes)), free: 1'b1, next: '0};
    end
  end

  assign frames_eff = (frames_q == 9'd0)   ? 9'd1 :
                      (frames_q > 9'd256)  ? 9'd256 : frames_q;
  assign heap_bytes = 21'(frames_eff) << ffba_pkg::PageShift;
  assign need       = (34'(req_q.request_bytes) + 34'd3) & ~34'd3;
  assign rel        = req_q.release_address - base_q;
  assign last       = SW'(count_q - CW'(1));

  assign in_stall_o  = (state_q != SIdle) || out_valid_q || cfg_valid_i;
  assign cfg_ready_o = (state_q == SIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic split_ok;
  assign split_ok = (34'(rd_e.size) >= need + 34'(ffba_pkg::HeaderBytes + 4))
                    && (count_q < CW'(ffba_pkg::MaxBlocks));

  always_comb begin
    we = 1'b0; waddr = cur_q; wdata = rd_e; raddr = cur_q;
    unique case (state_q)
      SAChk: begin
        raddr = rd_e.next;
        if (rd_e.free && 34'(rd_e.size) >= need) begin
          we = 1'b1;
          if (split_ok) wdata = '{size: ZW'(need), free: 1'b0, next: SW'(count_q)};
          else wdata = '{size: rd_e.size, free: 1'b0, next: rd_e.next};
        end
      end
      SFChk: begin
        raddr = rd_e.next;
        if (off_q + 34'(ffba_pkg::HeaderBytes) == 34'(rel) && !rd_e.free) begin
          we = 1'b1; wdata = '{size: rd_e.size, free: 1'b1, next: rd_e.next};
        end
      end
      SCChk:   raddr = rd_e.next;
      SCRdNx:  raddr = nx_q;
      SCMerge: begin
        we = 1'b1;
        wdata = '{size: ZW'(cure_q.size + ZW'(ffba_pkg::HeaderBytes) + rd_e.size),
                  free: 1'b1, next: rd_e.next};
      end
      SPRd:    raddr = p_q;
      SPChk: begin
        raddr = rd_e.next;
        if (rd_e.next == last) begin
          we = 1'b1; waddr = p_q; wdata = '{size: rd_e.size, free: rd_e.free, next: rem_q};
        end
      end
      SLRd:    raddr = last;
      SLMove: begin
        we = 1'b1; waddr = rem_q;
        wdata = (req_q.action == ffba_pkg::ActAlloc) ? nxe_q : rd_e;
      end
      SIdle, SARd, SFRd, SCRd, SDone: ;
      default: ;
    endcase
  end

  logic [ZW-1:0] split_size;
  assign split_size = ZW'(34'(rd_e.size) - need - 34'(ffba_pkg::HeaderBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; base_q <= ffba_pkg::BaseReset; frames_q <= ffba_pkg::FramesReset;
      count_q <= CW'(1); init_q <= 1'b1; out_valid_q <= 1'b0; rd0_q <= 1'b0;
      cur_q <= '0; nx_q <= '0; rem_q <= '0; p_q <= '0; pos_q <= '0; off_q <= '0;
    end else begin
      rd0_q <= (raddr == '0);
      if (we && waddr == '0) init_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cfg_valid_i && cfg_ready_o) begin
            if (cfg_index_i == ffba_pkg::CfgBase) base_q <= cfg_data_i;
            else frames_q <= cfg_data_i[8:0];
            init_q <= 1'b1; count_q <= CW'(1);
          end else if (in_valid_i && !in_stall_o) begin
            req_q <= in_data_i; cur_q <= '0; pos_q <= '0; off_q <= '0;
            if (in_data_i.action == ffba_pkg::ActAlloc) state_q <= SARd;
            else if (in_data_i.release_address == '0) begin
              out_q <= '{granted_address: '0, status: ffba_pkg::StNull};
              out_valid_q <= 1'b1;
            end else state_q <= SFRd;
          end
        end
        SARd: begin
          if (pos_q == count_q) begin
            out_q <= '{granted_address: '0, status: ffba_pkg::StNoSpace};
            state_q <= SDone;
          end else state_q <= SAChk;
        end
        SAChk: begin
          if (rd_e.free && 34'(rd_e.size) >= need) begin
            if (split_ok) begin
              // new tail slot written next cycle in SLMove
              nxe_q <= '{size: split_size, free: 1'b1, next: rd_e.next};
              rem_q <= SW'(count_q);
              count_q <= count_q + CW'(1);
              state_q <= SLMove;
              p_q <= '1;
            end else state_q <= SDone;
            out_q <= '{granted_address: base_q + off_q[31:0] + 32'(ffba_pkg::HeaderBytes),
                       status: ffba_pkg::StOk};
          end else begin
            off_q <= off_q + 34'(ffba_pkg::HeaderBytes) + 34'(rd_e.size);
            cur_q <= rd_e.next; pos_q <= pos_q + CW'(1); state_q <= SARd;
          end
        end
        SFRd: begin
          if (32'(heap_bytes) <= rel) begin
            out_q <= '{granted_address: '0, status: ffba_pkg::StOutside};
            state_q <= SDone;
          end else if (pos_q == count_q) begin
            out_q <= '{granted_address: '0, status: ffba_pkg::StNotBlock};
            state_q <= SDone;
          end else state_q <= SFChk;
        end
        SFChk: begin
          if (off_q + 34'(ffba_pkg::HeaderBytes) == 34'(rel)) begin
            if (rd_e.free) begin
              out_q <= '{granted_address: '0, status: ffba_pkg::StDouble};
              state_q <= SDone;
            end else begin
              out_q <= '{granted_address: '0, status: ffba_pkg::StOk};
              cur_q <= '0; pos_q <= '0; state_q <= SCRd;
            end
          end else begin
            off_q <= off_q + 34'(ffba_pkg::HeaderBytes) + 34'(rd_e.size);
            cur_q <= rd_e.next; pos_q <= pos_q + CW'(1); state_q <= SFRd;
          end
        end
        SCRd: state_q <= (pos_q + CW'(1) < count_q) ? SCChk : SDone;
        SCChk: begin
          cure_q <= rd_e; nx_q <= rd_e.next; state_q <= SCRdNx;
        end
        SCRdNx: begin
          if (cure_q.free && rd_e.free) state_q <= SCMerge;
          else begin
            cur_q <= nx_q; pos_q <= pos_q + CW'(1); state_q <= SCRd;
          end
        end
        SCMerge: begin
          rem_q <= nx_q; p_q <= '0; pos_q <= pos_q;
          off_q <= '0;
          if (nx_q == last) begin
            count_q <= count_q - CW'(1); state_q <= SCRd;
          end else state_q <= SPRd;
        end
        SPRd: state_q <= SPChk;
        SPChk: begin
          if (rd_e.next == last || off_q[CW-1:0] + CW'(2) >= count_q) state_q <= SLRd;
          else begin
            p_q <= rd_e.next; off_q <= off_q + 34'd1; state_q <= SPRd;
          end
        end
        SLRd: state_q <= SLMove;
        SLMove: begin
          if (p_q == '1 && req_q.action == ffba_pkg::ActAlloc) state_q <= SDone;
          else begin
            if (cur_q == last) cur_q <= rem_q;
            count_q <= count_q - CW'(1); state_q <= SCRd;
          end
        end
        SDone: begin
          out_valid_q <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CW'(ffba_pkg::MaxBlocks))
    else $error("block count out of range");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> in_stall_o)
    else $error("accepting while busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> state_q == SIdle && !out_valid_q)
    else $error("config while busy");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == SIdle)
    else $error("result pending during walk");
endmodule

[sv/ffba_ram.sv]
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
